// ===== rtl/asr_pkg.sv =====
// Shared types and constants for the asymmetric slew ramp.
// Channel payload structs, item modes, register indexes and field widths.
// No dependencies.
package asr_pkg;

   localparam int unsigned LEVEL_W      = 32;
   localparam int unsigned RATE_W       = 31;
   localparam int unsigned DT_W         = 16;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned FRAC_BITS_DEF = 16;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);

   typedef enum logic [1:0] {
      MODE_UPDATE = 2'd0,
      MODE_TARGET = 2'd1,
      MODE_FORCE  = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACCEL = 2'd0,
      CSR_DECEL = 2'd1
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]                mode;
      logic signed [LEVEL_W-1:0] value;
      logic [DT_W-1:0]           dt;
   } req_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      logic                      idle;
   } rsp_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] present;
      logic signed [LEVEL_W-1:0] goal;
   } state_type;

endpackage

// ===== rtl/asr_step.sv =====
// Single-pass datapath of the ramp: works out the next present and goal
// levels and the result for one item. Purely combinational.
// Depends on asr_pkg.
module asr_step #(
   parameter int unsigned FRAC_BITS = asr_pkg::FRAC_BITS_DEF
) (
   input  asr_pkg::req_type                  item,
   input  asr_pkg::state_type                cur,
   input  logic [asr_pkg::RATE_W-1:0]        accel_rate,
   input  logic [asr_pkg::RATE_W-1:0]        decel_rate,
   output asr_pkg::state_type                nxt,
   output asr_pkg::rsp_type                  result
);
   import asr_pkg::*;

   localparam int unsigned PROD_W  = RATE_W + DT_W;
   localparam int unsigned DIFF_W  = LEVEL_W + 1;
   localparam logic [DIFF_W-1:0] IdleGap = DIFF_W'((64'd1 << FRAC_BITS) / 64'd1000);
   localparam logic [PROD_W-1:0] StepMax = PROD_W'({RATE_W{1'b1}});

   logic                      growing;
   logic [RATE_W-1:0]         rate;
   logic [PROD_W-1:0]         prod;
   logic [PROD_W-1:0]         prod_shr;
   logic [RATE_W-1:0]         step;
   logic signed [DIFF_W-1:0]  step_s;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [DIFF_W-1:0]  moved;
   logic signed [LEVEL_W-1:0] advanced;
   logic signed [DIFF_W-1:0]  gap;
   logic [DIFF_W-1:0]         gap_abs;

   always_comb begin
      // magnitude grows on the present side of zero
      if (!cur.present[LEVEL_W-1]) begin
         growing = cur.goal > cur.present;
      end else begin
         growing = cur.goal < cur.present;
      end
      rate     = growing ? accel_rate : decel_rate;
      prod     = PROD_W'(rate) * PROD_W'(item.dt);
      prod_shr = prod >> FRAC_BITS;
      step     = (prod_shr > StepMax) ? {RATE_W{1'b1}} : prod_shr[RATE_W-1:0];
      step_s   = $signed({2'b00, step});
      diff     = $signed({cur.goal[LEVEL_W-1], cur.goal})
               - $signed({cur.present[LEVEL_W-1], cur.present});

      // land on the goal when the step would reach or pass it
      if (diff > step_s) begin
         moved    = $signed({cur.present[LEVEL_W-1], cur.present}) + step_s;
         advanced = moved[LEVEL_W-1:0];
      end else if (diff < -step_s) begin
         moved    = $signed({cur.present[LEVEL_W-1], cur.present}) - step_s;
         advanced = moved[LEVEL_W-1:0];
      end else begin
         moved    = '0;
         advanced = cur.goal;
      end

      nxt          = cur;
      result.level = cur.present;
      case (item.mode)
         MODE_UPDATE: begin
            nxt.present = advanced;
            if (item.dt == '0) begin
               result.level = '0;
            end else begin
               result.level = advanced;
            end
         end
         MODE_TARGET: begin
            nxt.goal = item.value;
         end
         MODE_FORCE: begin
            nxt.present  = item.value;
            nxt.goal     = item.value;
            result.level = item.value;
         end
         default: begin
            nxt = cur;
         end
      endcase

      gap     = $signed({nxt.goal[LEVEL_W-1], nxt.goal})
              - $signed({nxt.present[LEVEL_W-1], nxt.present});
      gap_abs = gap[DIFF_W-1] ? DIFF_W'(-gap) : DIFF_W'(gap);
      result.idle = gap_abs <= IdleGap;
   end

endmodule

// ===== rtl/asymmetric_slew_ramp.sv =====
// Top level of the asymmetric slew ramp: input register, rate and level
// registers, result register and handshakes. Depends on asr_pkg, asr_step.
//
//   channel  direction  handshake        payload
//   req_     in         valid / stall    asr_pkg::req_type (mode, value, dt)
//   rsp_     out        valid / stall    asr_pkg::rsp_type (level, idle)
//   csr_     in         valid / ready    index, 31-bit rate word
//
// One item per cycle sustained while rsp_stall is low; a result is offered once its
// item has passed the input register and then the result register, with the
// single multiply-and-compare path in asr_step between them.
// Synchronous reset clears both levels to zero and both rates to 1.0/s.
// A stalled result holds the input register; req_stall rises only when it
// is occupied and cannot move on.
module asymmetric_slew_ramp #(
   parameter int unsigned FRAC_BITS = asr_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  asr_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output asr_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [asr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [asr_pkg::RATE_W-1:0]       csr_wdata
);
   import asr_pkg::*;

   logic              item_vld_ff;
   req_type           item_ff;
   state_type         state_ff;
   state_type         state_in;
   logic [RATE_W-1:0] accel_ff;
   logic [RATE_W-1:0] decel_ff;
   logic              rsp_vld_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic              fire;
   logic              take;

   asr_step #(
      .FRAC_BITS (FRAC_BITS)
   ) u_step (
      .item       (item_ff),
      .cur        (state_ff),
      .accel_rate (accel_ff),
      .decel_rate (decel_ff),
      .nxt        (state_in),
      .result     (rsp_in)
   );

   assign fire      = item_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = item_vld_ff && !fire;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         state_ff    <= '0;
         accel_ff    <= RATE_RESET;
         decel_ff    <= RATE_RESET;
      end else begin
         if (take) begin
            item_vld_ff <= 1'b1;
         end else if (fire) begin
            item_vld_ff <= 1'b0;
         end
         if (fire) begin
            rsp_vld_ff <= 1'b1;
            state_ff   <= state_in;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCEL: accel_ff <= csr_wdata;
               CSR_DECEL: decel_ff <= csr_wdata;
               default: begin
                  accel_ff <= accel_ff;
               end
            endcase
         end
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed item produced no result");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_vld_ff && rsp_vld_ff)
      else $error("input stalled with room to advance");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(state_ff))
      else $error("levels changed without an item");

   a_force_is_idle: assert property (@(posedge clock) disable iff (reset)
      fire && item_ff.mode == MODE_FORCE |=>
         rsp_ff.idle && rsp_ff.level == $past(item_ff.value))
      else $error("forced level not reported");

   a_zero_dt_level: assert property (@(posedge clock) disable iff (reset)
      fire && item_ff.mode == MODE_UPDATE && item_ff.dt == '0 |=>
         rsp_ff.level == '0 && state_ff == $past(state_ff))
      else $error("update with zero dt moved the ramp");
`endif

endmodule

// ===== tb/sv/asr_ramp_checker.sv =====
// Scoreboard for the asymmetric slew ramp: watches the item, result and rate
// register channels, tracks ramp state and compares every result transfer.
// Depends on asr_pkg.
module asr_ramp_checker #(
   parameter int unsigned FRAC_BITS = asr_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  asr_pkg::req_type              req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  asr_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [asr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [asr_pkg::RATE_W-1:0]    csr_wdata,
   output int                            pending_count,
   output int                            fail_count
);

   timeunit 1ns;
   timeprecision 1ps;

   import asr_pkg::*;

   localparam longint IDLE_GAP   = (longint'(1) << FRAC_BITS) / 1000;
   localparam longint STEP_LIMIT = 64'h7FFF_FFFF;

   logic signed [LEVEL_W-1:0] present_lvl;
   logic signed [LEVEL_W-1:0] goal_lvl;
   logic [RATE_W-1:0]         accel_q;
   logic [RATE_W-1:0]         decel_q;
   rsp_type                   levels_due [$];
   int                        mismatches = 0;

   assign fail_count = mismatches;

   // Apply one item to the tracked ramp and return the result it must produce.
   function automatic rsp_type step_ramp(input req_type item);
      rsp_type                  res;
      longint                   cur;
      longint                   tgt;
      longint                   diff;
      longint                   step;
      logic                     grow;
      logic [RATE_W-1:0]        rate;
      logic [RATE_W+DT_W-1:0]   prod;
      cur = present_lvl;
      tgt = goal_lvl;
      case (item.mode)
         MODE_UPDATE: begin
            if (item.dt == '0) begin
               res.level = '0;
            end else begin
               diff = tgt - cur;
               if (diff != 0) begin
                  // magnitude grows on the present side of zero: accelerate
                  if (cur >= 0) grow = tgt > cur;
                  else          grow = tgt < cur;
                  rate = grow ? accel_q : decel_q;
                  prod = rate * item.dt;
                  step = longint'(prod >> FRAC_BITS);
                  if (step > STEP_LIMIT) step = STEP_LIMIT;
                  if (diff > step)       cur = cur + step;
                  else if (diff < -step) cur = cur - step;
                  else                   cur = tgt;
                  present_lvl = LEVEL_W'(cur);
               end
               res.level = present_lvl;
            end
         end
         MODE_TARGET: begin
            goal_lvl  = item.value;
            res.level = present_lvl;
         end
         MODE_FORCE: begin
            present_lvl = item.value;
            goal_lvl    = item.value;
            res.level   = present_lvl;
         end
         default: begin
            res.level = present_lvl;
         end
      endcase
      diff = longint'(goal_lvl) - longint'(present_lvl);
      if (diff < 0) diff = -diff;
      res.idle = (diff <= IDLE_GAP);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         present_lvl = '0;
         goal_lvl    = '0;
         accel_q     = RATE_RESET;
         decel_q     = RATE_RESET;
         levels_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (levels_due.size() == 0) begin
               $error("result transfer with nothing due: level %0d idle %0b",
                      got.level, got.idle);
               mismatches += 1;
            end else begin
               want = levels_due.pop_front();
               if (got.level !== want.level) begin
                  $error("level: expected %0d, got %0d", want.level, got.level);
                  mismatches += 1;
               end
               if (got.idle !== want.idle) begin
                  $error("idle: expected %0b, got %0b", want.idle, got.idle);
                  mismatches += 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCEL: accel_q = csr_wdata;
               CSR_DECEL: decel_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) levels_due.push_back(step_ramp(req_payload));
      end
      pending_count <= levels_due.size();
   end

endmodule

// ===== tb/sv/tb_asymmetric_slew_ramp.sv =====
// Top of the asymmetric slew ramp testbench: clock, reset, item and rate
// stimulus, result back-pressure and the verdict.
// Depends on asr_pkg, asymmetric_slew_ramp and asr_ramp_checker.
module tb_asymmetric_slew_ramp;

   timeunit 1ns;
   timeprecision 1ps;

   import asr_pkg::*;

   localparam logic [1:0]           MODE_SPARE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED2  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED3  = 2'd3;
   localparam logic signed [LEVEL_W-1:0] VALUE_TOP    = 32'sh7FFF_FFFF;
   localparam logic signed [LEVEL_W-1:0] VALUE_BOTTOM = 32'sh8000_0000;
   localparam logic [RATE_W-1:0]    RATE_TOP     = 31'h7FFF_FFFF;
   localparam logic [DT_W-1:0]      DT_TOP       = 16'hFFFF;
   localparam int                   PHASES       = 6;
   localparam int                   PHASE_ITEMS  = 150;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [RATE_W-1:0]    csr_wdata   = '0;
   int                   pending_count;
   int                   fail_count;

   int                        burst_left  = 0;
   logic signed [LEVEL_W-1:0] anchor      = '0;
   stall_style_type           stall_style = STALL_NONE;
   int                        stall_left  = 0;

   asymmetric_slew_ramp u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   asr_ramp_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   always #6 clock = ~clock;

   // Result back-pressure: switch to a randomly chosen style whenever the current one runs out.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_left  <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= (stall_left[2:0] < 3'd2);
      endcase
   end

   // Present one item and hold it until the transfer; open a new burst when due.
   task automatic send_item(input logic [1:0] mode, input logic signed [LEVEL_W-1:0] value,
                            input logic [DT_W-1:0] dt);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left -= 1;
      req_valid   <= 1'b1;
      req_payload <= '{mode: mode, value: value, dt: dt};
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off the sender until every result due has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic program_rates(input logic [RATE_W-1:0] accel,
                                input logic [RATE_W-1:0] decel, input bit touch_unused);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [RATE_W-1:0]    val [4];
      int                   n;
      idx = '{CSR_ACCEL, CSR_DECEL, CSR_UNUSED2, CSR_UNUSED3};
      val = '{accel, decel, RATE_W'($urandom), RATE_W'($urandom)};
      n = touch_unused ? 4 : 2;
      drain();
      for (int k = 0; k < n; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 7))
         0:       return RATE_TOP;
         1:       return RATE_W'(1);
         2:       return '0;
         3:       return RATE_RESET;
         4, 5:    return RATE_W'($urandom_range(1, 1 << 20));
         default: return RATE_W'($urandom);
      endcase
   endfunction

   // Mostly targets near the last one followed by updates, so ramps do arrive.
   task automatic send_random_item();
      logic [1:0]                mode;
      logic signed [LEVEL_W-1:0] value;
      logic [DT_W-1:0]           dt;
      int                        pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)      mode = MODE_UPDATE;
      else if (pick < 85) mode = MODE_TARGET;
      else if (pick < 96) mode = MODE_FORCE;
      else                mode = MODE_SPARE;
      case ($urandom_range(0, 9))
         0:       value = VALUE_TOP;
         1:       value = VALUE_BOTTOM;
         2, 3:    value = $urandom;
         default: value = anchor + LEVEL_W'($urandom_range(0, 1 << 18)) - LEVEL_W'(1 << 17);
      endcase
      if (mode == MODE_TARGET || mode == MODE_FORCE) anchor = value;
      case ($urandom_range(0, 9))
         0:         dt = '0;
         1:         dt = DT_TOP;
         2:         dt = DT_W'(1);
         3, 4, 5:   dt = DT_W'($urandom_range(1, 255));
         default:   dt = DT_W'($urandom);
      endcase
      send_item(mode, value, dt);
   endtask

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default rates: level already on goal, zero dt, both extremes
      send_item(MODE_UPDATE, '0, DT_W'(1));
      send_item(MODE_UPDATE, '0, '0);
      send_item(MODE_FORCE, VALUE_TOP, DT_TOP);
      send_item(MODE_TARGET, VALUE_BOTTOM, '0);
      send_item(MODE_UPDATE, $urandom, DT_TOP);
      send_item(MODE_UPDATE, $urandom, '0);
      // negative side: moving away from zero, then braking back across it
      send_item(MODE_FORCE, -32'sd1000, '0);
      send_item(MODE_TARGET, -32'sd200000, '0);
      send_item(MODE_UPDATE, '0, 16'h8000);
      send_item(MODE_TARGET, 32'sd500, '0);
      send_item(MODE_UPDATE, '0, DT_TOP);
      // idle threshold either side
      send_item(MODE_TARGET, 32'sd566, '0);
      send_item(MODE_UPDATE, '0, DT_W'(1));
      send_item(MODE_SPARE, $urandom, DT_W'($urandom));

      // widest rates, full-range swing, then two full steps toward the goal
      program_rates(RATE_TOP, RATE_TOP, 1'b1);
      send_item(MODE_FORCE, VALUE_BOTTOM, '0);
      send_item(MODE_TARGET, VALUE_TOP, '0);
      send_item(MODE_UPDATE, '0, DT_TOP);
      send_item(MODE_UPDATE, '0, DT_TOP);

      // zero rates: nothing moves
      program_rates('0, '0, 1'b0);
      send_item(MODE_TARGET, -32'sd5000, '0);
      send_item(MODE_UPDATE, '0, DT_TOP);

      // smallest rate rounds the step down to nothing
      program_rates(RATE_W'(1), RATE_W'(1), 1'b0);
      send_item(MODE_FORCE, '0, '0);
      send_item(MODE_TARGET, 32'sd10, '0);
      send_item(MODE_UPDATE, '0, DT_TOP);

      for (int p = 0; p < PHASES; p++) begin
         program_rates(pick_rate(), pick_rate(), $urandom_range(0, 1));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) == 0) drain();
            send_random_item();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/asr_pkg.sv
rtl/asr_step.sv
rtl/asymmetric_slew_ramp.sv
tb/sv/asr_ramp_checker.sv
tb/sv/tb_asymmetric_slew_ramp.sv
